// ===== sv/hcbp_pkg.sv =====
// Shared constants and types for the Huffman code bit packer.
// No dependencies; compile first.
`default_nettype none

package hcbp_pkg;

   localparam int SYMBOL_COUNT = 128;
   localparam int SYMBOL_W     = $clog2(SYMBOL_COUNT);
   localparam int MAX_CODE_LEN = 32;
   localparam int CODE_W       = 32;
   localparam int LEN_W        = 6;
   localparam int LEN_CAP      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
   localparam int BYTE_W       = 8;
   localparam int BUF_W        = CODE_W + BYTE_W;
   localparam int NB_W         = $clog2(BUF_W);
   localparam int ACTION_W     = 2;

   localparam logic [SYMBOL_W-1:0] END_SYMBOL_RESET = SYMBOL_W'(26);

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD   = 2'd0,
      ACT_ENCODE = 2'd1,
      ACT_FINISH = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   // Lookup result handed from the table stage to the packer.
   typedef struct packed {
      logic              is_finish;
      logic              hit;
      logic [CODE_W-1:0] code;   // left-aligned, zeros below the length
      logic [LEN_W-1:0]  len;
   } hcbp_lookup_type;

endpackage

`default_nettype wire

// ===== sv/hcbp_if.sv =====
// Valid/ready channel interfaces for request and response words.
// Depends on hcbp_pkg.
`default_nettype none

interface hcbp_req_if;
   logic                          valid;
   logic                          ready;
   logic [hcbp_pkg::ACTION_W-1:0] action;
   logic [hcbp_pkg::SYMBOL_W-1:0] symbol;
   logic [hcbp_pkg::CODE_W-1:0]   code_bits;
   logic [hcbp_pkg::LEN_W-1:0]    code_length;

   modport source (output valid, action, symbol, code_bits, code_length, input ready);
   modport sink   (input valid, action, symbol, code_bits, code_length, output ready);
endinterface

interface hcbp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [hcbp_pkg::BYTE_W-1:0] out_byte;
   logic                        last_of_run;
   logic                        missing_code;

   modport source (output valid, out_byte, last_of_run, missing_code, input ready);
   modport sink   (input valid, out_byte, last_of_run, missing_code, output ready);
endinterface

`default_nettype wire

// ===== sv/hcbp_code_table.sv =====
// Code table (memory plus per-entry valid bits) and the lookup stage register.
// Depends on hcbp_pkg.
`default_nettype none

module hcbp_code_table (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [hcbp_pkg::ACTION_W-1:0] req_action,
   input  wire logic [hcbp_pkg::SYMBOL_W-1:0] req_symbol,
   input  wire logic [hcbp_pkg::CODE_W-1:0]   req_code_bits,
   input  wire logic [hcbp_pkg::LEN_W-1:0]    req_code_length,
   input  wire logic [hcbp_pkg::SYMBOL_W-1:0] end_symbol,
   input  wire logic                          lk_take,
   output logic                               lk_valid,
   output hcbp_pkg::hcbp_lookup_type          lk_word
);
   import hcbp_pkg::*;

   logic [CODE_W+LEN_W-1:0] mem [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0] valid_ff;

   logic                    lk_valid_ff, lk_valid_in;
   logic                    finish_ff, hit_ff;
   logic [CODE_W+LEN_W-1:0] rd_ff;

   logic                    accept, is_load, is_lookup;
   logic [LEN_W-1:0]        len_cap, sh_amt;
   logic [CODE_W-1:0]       code_la;
   logic [SYMBOL_W-1:0]     rd_addr;

   assign req_ready = !lk_valid_ff || lk_take;
   assign accept    = req_valid && req_ready;
   assign is_load   = accept && (req_action == ACT_LOAD);
   assign is_lookup = accept && ((req_action == ACT_ENCODE) || (req_action == ACT_FINISH));
   assign rd_addr   = (req_action == ACT_ENCODE) ? req_symbol : end_symbol;

   // Saturate the length and left-align the code so the packer needs no mask.
   always_comb begin
      len_cap = (req_code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : req_code_length;
      sh_amt  = LEN_W'(CODE_W) - len_cap;
      if (len_cap == '0) begin
         code_la = '0;
      end else begin
         code_la = req_code_bits << sh_amt;
      end
   end

   always_comb begin
      lk_valid_in = lk_valid_ff;
      if (is_lookup) begin
         lk_valid_in = 1'b1;
      end else if (lk_take) begin
         lk_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         lk_valid_ff <= 1'b0;
      end else begin
         lk_valid_ff <= lk_valid_in;
         if (is_load) begin
            valid_ff[req_symbol] <= (len_cap != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (is_load) begin
         mem[req_symbol] <= {code_la, len_cap};
      end
   end

   always_ff @(posedge clock) begin
      if (is_lookup) begin
         rd_ff     <= mem[rd_addr];
         hit_ff    <= valid_ff[rd_addr];
         finish_ff <= (req_action == ACT_FINISH);
      end
   end

   assign lk_valid          = lk_valid_ff;
   assign lk_word.is_finish = finish_ff;
   assign lk_word.hit       = hit_ff;
   assign lk_word.code      = rd_ff[CODE_W+LEN_W-1:LEN_W];
   assign lk_word.len       = rd_ff[LEN_W-1:0];

endmodule

`default_nettype wire

// ===== sv/hcbp_packer.sv =====
// Bit accumulator and byte emitter with the response output register.
// Depends on hcbp_pkg.
`default_nettype none

module hcbp_packer (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      lk_valid,
   input  wire hcbp_pkg::hcbp_lookup_type lk_word,
   output logic                           lk_take,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [hcbp_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                           rsp_last_of_run,
   output logic                           rsp_missing_code
);
   import hcbp_pkg::*;

   // sh_ff holds queued bits MSB first; bits below nb_ff are always zero.
   logic [BUF_W-1:0]  sh_ff, sh_in;
   logic [NB_W-1:0]   nb_ff, nb_in, rem;
   logic              miss_ff, miss_in;
   logic              pad_ff, pad_in;

   logic              vld_ff, vld_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              last_ff, last_in;
   logic              mc_ff, mc_in;

   logic              busy, slot_free, emit;

   assign busy      = miss_ff || (nb_ff >= NB_W'(BYTE_W)) || pad_ff;
   assign slot_free = !vld_ff || rsp_ready;
   assign emit      = busy && slot_free;
   assign lk_take   = lk_valid && !busy;
   assign rem       = nb_ff - NB_W'(BYTE_W);

   always_comb begin
      sh_in   = sh_ff;
      nb_in   = nb_ff;
      miss_in = miss_ff;
      pad_in  = pad_ff;
      vld_in  = vld_ff && !rsp_ready;
      byte_in = byte_ff;
      last_in = last_ff;
      mc_in   = mc_ff;

      if (lk_take) begin
         miss_in = !lk_word.hit;
         pad_in  = lk_word.is_finish;
         if (lk_word.hit) begin
            sh_in = sh_ff | ({lk_word.code, {BYTE_W{1'b0}}} >> nb_ff[2:0]);
            nb_in = nb_ff + NB_W'(lk_word.len);
         end
      end else if (emit) begin
         vld_in = 1'b1;
         if (miss_ff) begin
            // missing-code word comes before any bytes of this item
            miss_in = 1'b0;
            byte_in = '0;
            mc_in   = 1'b1;
            last_in = !pad_ff || (nb_ff == '0);
            if (pad_ff && (nb_ff == '0)) begin
               pad_in = 1'b0;
            end
         end else if (nb_ff >= NB_W'(BYTE_W)) begin
            byte_in = sh_ff[BUF_W-1 -: BYTE_W];
            mc_in   = 1'b0;
            sh_in   = sh_ff << BYTE_W;
            nb_in   = rem;
            last_in = pad_ff ? (rem == '0) : (rem < NB_W'(BYTE_W));
            if (pad_ff && (rem == '0)) begin
               pad_in = 1'b0;
            end
         end else begin
            // zero-padded final partial byte
            byte_in = sh_ff[BUF_W-1 -: BYTE_W];
            mc_in   = 1'b0;
            last_in = 1'b1;
            sh_in   = '0;
            nb_in   = '0;
            pad_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sh_ff   <= '0;
         nb_ff   <= '0;
         miss_ff <= 1'b0;
         pad_ff  <= 1'b0;
         vld_ff  <= 1'b0;
      end else begin
         sh_ff   <= sh_in;
         nb_ff   <= nb_in;
         miss_ff <= miss_in;
         pad_ff  <= pad_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      mc_ff   <= mc_in;
   end

   assign rsp_valid        = vld_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_last_of_run  = last_ff;
   assign rsp_missing_code = mc_ff;

endmodule

`default_nettype wire

// ===== sv/huffman_code_bit_packer_core.sv =====
// Static Huffman encoder bit packer: request word in, packed byte words out.
// Each request word is load, encode or finish. Loads write a 128-entry code table
// (code up to 32 bits, length saturated at 32, length zero means no code). An
// encode looks up its symbol, a finish looks up csr end_symbol (reset 26), and
// the code is shifted MSB first into a byte accumulator; every full byte leaves
// as one response word, earliest bit in bit 7. A finish then pads the partial
// byte with zeros and sends it. A symbol with no code gives one response word
// with missing_code set and out_byte zero, and adds nothing. last_of_run marks
// the final response word of each request word.
// Timing: a response word passes the lookup register, the bit accumulator and
// the response register in that order. Words with no response (loads, short
// codes) are taken one per cycle while the packer is not busy. A word causing
// n response words holds the packer until they have left, since the byte-wide
// response register moves one byte a cycle while the response channel is ready
// (up to five for a 32-bit code on a finish); the table stage takes the next
// request word meanwhile. The per-entry valid bits are cleared by reset, so no
// clearing pass is needed. Write csr end_symbol only while the block is idle.
// Depends on hcbp_pkg, hcbp_if, hcbp_code_table, hcbp_packer.
`default_nettype none

module huffman_code_bit_packer_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   hcbp_req_if.sink                           req_chan,
   hcbp_rsp_if.source                         rsp_chan,
   input  wire logic                          csr_write_enable,
   input  wire logic [hcbp_pkg::SYMBOL_W-1:0] csr_write_data
);
   import hcbp_pkg::*;

   logic [SYMBOL_W-1:0] end_sym_ff, end_sym_in;
   logic                lk_valid, lk_take;
   hcbp_lookup_type     lk_word;

   // end_symbol register
   assign end_sym_in = csr_write_enable ? csr_write_data : end_sym_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         end_sym_ff <= END_SYMBOL_RESET;
      end else begin
         end_sym_ff <= end_sym_in;
      end
   end

   // stage 1: table write on load, registered lookup on encode/finish
   hcbp_code_table u_table (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_ready       (req_chan.ready),
      .req_action      (req_chan.action),
      .req_symbol      (req_chan.symbol),
      .req_code_bits   (req_chan.code_bits),
      .req_code_length (req_chan.code_length),
      .end_symbol      (end_sym_ff),
      .lk_take         (lk_take),
      .lk_valid        (lk_valid),
      .lk_word         (lk_word)
   );

   // stage 2: accumulate bits and emit one byte per cycle while the output is ready
   hcbp_packer u_packer (
      .clock            (clock),
      .reset            (reset),
      .lk_valid         (lk_valid),
      .lk_word          (lk_word),
      .lk_take          (lk_take),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_out_byte     (rsp_chan.out_byte),
      .rsp_last_of_run  (rsp_chan.last_of_run),
      .rsp_missing_code (rsp_chan.missing_code)
   );

endmodule

`default_nettype wire

// ===== sv/hcbp_checker.sv =====
// Port-level checks on the response channel, bound to the top level.
// Depends on hcbp_pkg and huffman_code_bit_packer_core.
`default_nettype none

module hcbp_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [hcbp_pkg::BYTE_W-1:0] rsp_out_byte,
   input wire logic                        rsp_last_of_run,
   input wire logic                        rsp_missing_code
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_byte) && $stable(rsp_last_of_run)
                                  && $stable(rsp_missing_code))
      else $error("response payload changed while stalled");

   a_missing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_missing_code |-> rsp_out_byte == '0)
      else $error("missing-code word carries a nonzero byte");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind huffman_code_bit_packer_core hcbp_checker u_hcbp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_out_byte     (rsp_chan.out_byte),
   .rsp_last_of_run  (rsp_chan.last_of_run),
   .rsp_missing_code (rsp_chan.missing_code)
);

`default_nettype wire
